// File: design/hs_pkg.sv
// shared types, constants and helpers for the heap sort core
package hs_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IO_WIDTH   = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   typedef logic [DATA_WIDTH-1:0] elem_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   // element store access for one cycle
   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      elem_type wr_data;
      logic     rd_en;
      idx_type  rd_addr_a;
      idx_type  rd_addr_b;
   } mem_req_type;

   typedef enum logic [10:0] {
      ST_LOAD    = 11'b000_0000_0001,
      ST_BUILD   = 11'b000_0000_0010,
      ST_ROOT    = 11'b000_0000_0100,
      ST_READ    = 11'b000_0000_1000,
      ST_CMPL    = 11'b000_0001_0000,
      ST_CMPR    = 11'b000_0010_0000,
      ST_SORT    = 11'b000_0100_0000,
      ST_SWAP_RD = 11'b000_1000_0000,
      ST_SWAP_WR = 11'b001_0000_0000,
      ST_EMIT_RD = 11'b010_0000_0000,
      ST_EMIT    = 11'b100_0000_0000
   } state_type;

   // low data bits of a request value
   function automatic elem_type to_elem(logic [IO_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[DATA_WIDTH-1:0];
   endfunction

   // element pattern as it leaves on the result channel
   function automatic logic [IO_WIDTH-1:0] to_out(elem_type e);
      logic [63:0] w;
      w = 64'(e);
      return w[IO_WIDTH-1:0];
   endfunction

endpackage

// File: design/hs_if.sv
// valid/ready channel interfaces for requests and sorted results
interface hs_req_if import hs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] value;
   logic                       last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface hs_rsp_if import hs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] sorted_value;
   logic                       last_result;
   logic                       overflow;

   modport source (output valid, output sorted_value, output last_result, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_result, input overflow,
                   output ready);
endinterface

// File: design/hs_store.sv
// element store: one write port, two registered read ports
module hs_store import hs_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output elem_type    rd_data_a,
   output elem_type    rd_data_b
);

   elem_type store_mem [CAPACITY];
   elem_type rd_a_ff;
   elem_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      // read data holds while no read is issued
      if (mem_req.rd_en) begin
         rd_a_ff <= store_mem[mem_req.rd_addr_a];
         rd_b_ff <= store_mem[mem_req.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: design/hs_cmp.sv
// shared signed compare unit
module hs_cmp import hs_pkg::*; (
   input  elem_type cmp_a,
   input  elem_type cmp_b,
   output logic     a_gt_b
);

   assign a_gt_b = $signed(cmp_a) > $signed(cmp_b);

endmodule

// File: design/heap_sort_core.sv
// heap sort core: element store, shared comparator and sort sequencer
// one request per cycle while collecting a set; the last request starts the sort
// sift-down: read, compare-left, compare-right per level visited, settling level included;
// a build parent adds build and root states, a root/end swap sort, swap-read and swap-write
// results leave one by one; the next set is taken after the final result loads
// synchronous active-high reset clears the sequencer and counters; no clearing pass
module heap_sort_core import hs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hs_req_if.sink     req_chan,
   hs_rsp_if.source   rsp_chan
);

   // sequencer state
   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;      // elements held for the current set
   logic      dropped_ff, dropped_in;  // some element of this set was dropped
   cnt_type   size_ff, size_in;        // heap size of the running sift
   cnt_type   end_ff, end_in;          // end of the shrinking heap
   idx_type   build_ff, build_in;      // parents still to sift while building
   idx_type   idx_ff, idx_in;          // hole being sifted down
   logic      sort_ff, sort_in;        // sorting phase (vs heap build)
   logic      first_ff, first_in;      // sifted value arrives from the root read

   // datapath registers
   elem_type  cur_ff, cur_in;          // value being sifted down
   elem_type  best_ff, best_in;        // larger of hole value and left child
   idx_type   best_idx_ff, best_idx_in;
   idx_type   k_ff, k_in;              // result counter

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IO_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_load;

   mem_req_type mem_req;
   elem_type    rd_data_a;
   elem_type    rd_data_b;
   elem_type    cmp_a;
   elem_type    cmp_b;
   logic        a_gt_b;

   logic [IDX_W+1:0] left_idx;
   logic [IDX_W+1:0] right_idx;
   logic             left_ok;
   logic             right_ok;
   cnt_type          end_dec;
   cnt_type          n_new;
   logic             req_fire;

   hs_store u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   hs_cmp u_cmp (
      .cmp_a  (cmp_a),
      .cmp_b  (cmp_b),
      .a_gt_b (a_gt_b)
   );

   // children of the hole, checked against the heap size
   assign left_idx  = {1'b0, idx_ff, 1'b1};
   assign right_idx = {1'b0, idx_ff, 1'b0} + (IDX_W + 2)'(2);
   assign left_ok   = left_idx < (IDX_W + 2)'(size_ff);
   assign right_ok  = right_idx < (IDX_W + 2)'(size_ff);
   assign end_dec   = end_ff - CNT_W'(1);

   // collecting only in the load state
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // comparator operands: left child vs hole value, then right child vs best
   always_comb begin
      if (state_ff == ST_CMPL) begin
         cmp_a = rd_data_a;
         cmp_b = cur_ff;
      end else begin
         cmp_a = rd_data_b;
         cmp_b = best_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      size_in      = size_ff;
      end_in       = end_ff;
      build_in     = build_ff;
      idx_in       = idx_ff;
      sort_in      = sort_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      k_in         = k_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      n_new        = count_ff;

      mem_req           = '0;
      mem_req.rd_addr_a = idx_ff;
      mem_req.rd_addr_b = idx_ff;
      mem_req.wr_addr   = idx_ff;
      mem_req.wr_data   = cur_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CNT_W'(CAPACITY)) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = count_ff[IDX_W-1:0];
                  mem_req.wr_data = to_elem(req_chan.value);
                  n_new           = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               count_in = n_new;
               if (req_chan.last_item) begin
                  size_in  = n_new;
                  end_in   = n_new;
                  build_in = IDX_W'(n_new >> 1);
                  sort_in  = 1'b0;
                  state_in = ST_BUILD;
               end
            end
         end
         ST_BUILD: begin
            // sift each parent, last parent first
            if (build_ff != '0) begin
               idx_in   = build_ff - IDX_W'(1);
               build_in = build_ff - IDX_W'(1);
               state_in = ST_ROOT;
            end else begin
               sort_in  = 1'b1;
               state_in = ST_SORT;
            end
         end
         ST_ROOT: begin
            mem_req.rd_en = 1'b1;
            first_in      = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            if (first_ff) begin
               cur_in = rd_data_a;
            end
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr_a = left_idx[IDX_W-1:0];
            mem_req.rd_addr_b = right_idx[IDX_W-1:0];
            first_in          = 1'b0;
            state_in          = ST_CMPL;
         end
         ST_CMPL: begin
            if (left_ok && a_gt_b) begin
               best_in     = rd_data_a;
               best_idx_in = left_idx[IDX_W-1:0];
            end else begin
               best_in     = cur_ff;
               best_idx_in = idx_ff;
            end
            state_in = ST_CMPR;
         end
         ST_CMPR: begin
            mem_req.wr_en = 1'b1;
            if (right_ok && a_gt_b) begin
               // right child moves up into the hole
               mem_req.wr_data = rd_data_b;
               idx_in          = right_idx[IDX_W-1:0];
               state_in        = ST_READ;
            end else if (best_idx_ff != idx_ff) begin
               mem_req.wr_data = best_ff;
               idx_in          = best_idx_ff;
               state_in        = ST_READ;
            end else begin
               // hole settled: the sifted value lands here
               mem_req.wr_data = cur_ff;
               state_in        = sort_ff ? ST_SORT : ST_BUILD;
            end
         end
         ST_SORT: begin
            if (end_ff > CNT_W'(1)) begin
               state_in = ST_SWAP_RD;
            end else begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_SWAP_RD: begin
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr_a = '0;
            mem_req.rd_addr_b = end_dec[IDX_W-1:0];
            state_in          = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            // max goes to the end, the end value sifts down from the root
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = end_dec[IDX_W-1:0];
            mem_req.wr_data = rd_data_a;
            cur_in          = rd_data_b;
            idx_in          = '0;
            size_in         = end_dec;
            end_in          = end_dec;
            first_in        = 1'b0;
            state_in        = ST_READ;
         end
         ST_EMIT_RD: begin
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr_a = k_ff;
            state_in          = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = to_out(rd_data_a);
               rsp_last_in  = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;
               rsp_ovf_in   = dropped_ff;
               if (rsp_last_in) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         size_ff      <= '0;
         end_ff       <= '0;
         build_ff     <= '0;
         idx_ff       <= '0;
         sort_ff      <= 1'b0;
         first_ff     <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         size_ff      <= size_in;
         end_ff       <= end_in;
         build_ff     <= build_in;
         idx_ff       <= idx_in;
         sort_ff      <= sort_in;
         first_ff     <= first_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = rsp_value_ff;
   assign rsp_chan.last_result  = rsp_last_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

   // store never holds more than its capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   // the hole stays inside the heap while sifting
   a_hole_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMPR) |-> (CNT_W'(idx_ff) < size_ff))
      else $error("sift index outside heap");

   // heap bounds never pass the element count outside the load state
   a_heap_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (end_ff <= count_ff && size_ff <= count_ff))
      else $error("heap bound beyond element count");

   // the final result returns the core to an empty set
   a_set_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == ST_LOAD && count_ff == '0 && !dropped_ff))
      else $error("set not cleared after final result");

endmodule
